// ----- hw/rtl/alm_pkg.sv -----
`timescale 1ns / 1ps
// alm_pkg: shared constants, types and power-curve tables of the audio level meter
// no dependencies; used by every module of the block

package alm_pkg;

  localparam int unsigned MAX_SAMPLES    = 4096;
  localparam int unsigned CNT_W          = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W          = 43;
  localparam int unsigned SMP_W          = 16;
  localparam int unsigned Q16_W          = 17;
  localparam logic [Q16_W-1:0] Q16_ONE   = 17'h10000;
  localparam int unsigned POW_TABLE_BITS = 10;
  localparam int unsigned FRAC_BITS      = 16 - POW_TABLE_BITS;
  localparam int unsigned TAB_LEN        = (1 << POW_TABLE_BITS) + 1;
  localparam int unsigned IDX_W          = POW_TABLE_BITS + 1;
  localparam int unsigned DIV_W          = 48;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_W + 1);
  localparam int unsigned SQRT_W         = 33;
  localparam int unsigned LOG_FRAC       = 24;
  localparam int unsigned ADDR_W         = 5;
  localparam int unsigned DATA_W         = 32;

  localparam logic [Q16_W-1:0] GATE_RST      = 17'd393;
  localparam logic [Q16_W-1:0] RMS_CEIL_RST  = 17'd16384;
  localparam logic [Q16_W-1:0] PEAK_CEIL_RST = 17'd58982;
  localparam logic [Q16_W-1:0] WEIGHT_RST    = 17'd47186;
  localparam logic [Q16_W-1:0] ATTACK_RST    = 17'd38011;
  localparam logic [Q16_W-1:0] RELEASE_RST   = 17'd10486;

  typedef enum logic [2:0] {
    REG_GATE,
    REG_RMS_CEIL,
    REG_PEAK_CEIL,
    REG_PEAK_WEIGHT,
    REG_ATTACK,
    REG_RELEASE
  } reg_idx_e;

  typedef struct packed {
    logic [Q16_W-1:0] gate_level;
    logic [Q16_W-1:0] rms_ceiling;
    logic [Q16_W-1:0] peak_ceiling;
    logic [Q16_W-1:0] peak_weight;
    logic [Q16_W-1:0] attack_gain;
    logic [Q16_W-1:0] release_gain;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_MAP_RMS,
    DIV_MAP_PEAK
  } div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_SQRT,
    S_MAPR_GO,
    S_MAPR_WAIT,
    S_MAPP_GO,
    S_MAPP_WAIT,
    S_ROM,
    S_MIX,
    S_WEIGHT,
    S_SMOOTH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic     take;
    logic     div_start;
    div_sel_e div_sel;
    logic     map_store;
    logic     sqrt_start;
    logic     rom_rd;
    logic     mix;
    logic     weight;
    logic     smooth;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic out_busy;
  } status_t;

  typedef logic [Q16_W-1:0] shape_tab_t [TAB_LEN];

  function automatic logic [63:0] isqrt64(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = xin;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 64'd0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_q24(input logic [31:0] v);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    frac = 64'd0;
    while ((v >> e) > 32'd1) e++;
    m = {32'd0, v} << (30 - e);
    for (int k = 1; k <= int'(LOG_FRAC); k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (int'(LOG_FRAC) - k));
      end
    end
    return (64'(e) << LOG_FRAC) + frac;
  endfunction

  function automatic shape_tab_t build_shape(input logic [63:0] num);
    shape_tab_t  tab;
    logic [63:0] q [LOG_FRAC+1];
    logic [63:0] mag;
    logic [63:0] sc;
    logic [63:0] ip;
    logic [63:0] y;
    q[0] = 64'd0;
    q[1] = isqrt64(64'd1 << 59);
    for (int k = 2; k <= int'(LOG_FRAC); k++) q[k] = isqrt64(q[k-1] << 30);
    tab[0] = '0;
    for (int i = 1; i < int'(TAB_LEN); i++) begin
      mag = (64'(POW_TABLE_BITS) << LOG_FRAC) - log2_q24(32'(i));
      sc  = mag * num / 64'd20;
      ip  = sc >> LOG_FRAC;
      y   = 64'd1 << 30;
      for (int k = 1; k <= int'(LOG_FRAC); k++) begin
        if (sc[int'(LOG_FRAC) - k]) y = (y * q[k]) >> 30;
      end
      tab[i] = (ip + 64'd14 >= 64'd64) ? '0 : Q16_W'(y >> (ip + 64'd14));
    end
    return tab;
  endfunction

  localparam shape_tab_t RMS_SHAPE  = build_shape(64'd9);
  localparam shape_tab_t PEAK_SHAPE = build_shape(64'd11);

endpackage

// ----- hw/rtl/audio_level_meter.sv -----
`timescale 1ns / 1ps
// audio_level_meter: rms/peak level meter with attack/release smoothing, top level
// depends on alm_pkg, alm_regs, alm_ctrl, alm_dp, alm_div
//
//   channel   signals                                          direction
//   samples   in_valid_i/in_ready_o, sample_i, last_i         in
//   levels    out_valid_o/out_ready_i, rms/peak/smoothed/ovf   out
//   config    psel penable pwrite paddr pwdata prdata pready   apb
//
// samples without last are taken one per cycle while the meter is idle
// a request with last starts the end-of-run work:
//   the divider run three times plus a 17-step square root
// the result sits in an output register, so the next run's work waits only for it
// reset clears accumulators and the smoothed level; registers take their defaults

module audio_level_meter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           sample_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [16:0]                  rms_level_o,
  output logic [16:0]                  peak_level_o,
  output logic [16:0]                  smoothed_level_o,
  output logic                         overflow_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alm_pkg::ADDR_W-1:0]   paddr,
  input  logic [alm_pkg::DATA_W-1:0]   pwdata,
  output logic [alm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  alm_pkg::cfg_t    cfg;
  alm_pkg::cmd_t    cmd;
  alm_pkg::status_t status;

  alm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  alm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  alm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_i         (sample_i),
    .last_i           (last_i),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .rms_level_o      (rms_level_o),
    .peak_level_o     (peak_level_o),
    .smoothed_level_o (smoothed_level_o),
    .overflow_o       (overflow_o)
  );

endmodule

// ----- hw/rtl/alm_div.sv -----
`timescale 1ns / 1ps
// alm_div: restoring divider, one quotient bit per cycle
// depends on alm_pkg

module alm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [alm_pkg::DIV_W-1:0]   dividend_i,
  input  logic [alm_pkg::Q16_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [alm_pkg::DIV_W-1:0]   quotient_o
);

  logic [alm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [alm_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [alm_pkg::Q16_W-1:0]     rem_q, rem_d;
  logic [alm_pkg::Q16_W-1:0]     dvs_q, dvs_d;
  logic [alm_pkg::Q16_W:0]       rem_sh;
  logic [alm_pkg::Q16_W:0]       rem_sub;
  logic                          ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[alm_pkg::DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      cnt_d = alm_pkg::DIV_CNT_W'(alm_pkg::DIV_W);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[alm_pkg::DIV_W-2:0], ge};
      rem_d = ge ? rem_sub[alm_pkg::Q16_W-1:0] : rem_sh[alm_pkg::Q16_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/alm_regs.sv -----
`timescale 1ns / 1ps
// alm_regs: apb configuration registers of the level meter
// depends on alm_pkg

module alm_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alm_pkg::ADDR_W-1:0]   paddr,
  input  logic [alm_pkg::DATA_W-1:0]   pwdata,
  output logic [alm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output alm_pkg::cfg_t                cfg_o
);

  alm_pkg::cfg_t             cfg_q, cfg_d;
  alm_pkg::reg_idx_e         idx;
  logic [alm_pkg::Q16_W-1:0] wval;
  logic [alm_pkg::Q16_W-1:0] rval;

  assign pready = 1'b1;
  assign idx    = alm_pkg::reg_idx_e'(paddr[alm_pkg::ADDR_W-1:2]);
  assign wval   = pwdata[alm_pkg::Q16_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        alm_pkg::REG_GATE:        cfg_d.gate_level   = wval;
        alm_pkg::REG_RMS_CEIL:    cfg_d.rms_ceiling  = wval;
        alm_pkg::REG_PEAK_CEIL:   cfg_d.peak_ceiling = wval;
        alm_pkg::REG_PEAK_WEIGHT: cfg_d.peak_weight  = wval;
        alm_pkg::REG_ATTACK:      cfg_d.attack_gain  = wval;
        alm_pkg::REG_RELEASE:     cfg_d.release_gain = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      alm_pkg::REG_GATE:        rval = cfg_q.gate_level;
      alm_pkg::REG_RMS_CEIL:    rval = cfg_q.rms_ceiling;
      alm_pkg::REG_PEAK_CEIL:   rval = cfg_q.peak_ceiling;
      alm_pkg::REG_PEAK_WEIGHT: rval = cfg_q.peak_weight;
      alm_pkg::REG_ATTACK:      rval = cfg_q.attack_gain;
      alm_pkg::REG_RELEASE:     rval = cfg_q.release_gain;
      default:                  rval = '0;
    endcase
  end

  assign prdata = alm_pkg::DATA_W'(rval);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_level   <= alm_pkg::GATE_RST;
      cfg_q.rms_ceiling  <= alm_pkg::RMS_CEIL_RST;
      cfg_q.peak_ceiling <= alm_pkg::PEAK_CEIL_RST;
      cfg_q.peak_weight  <= alm_pkg::WEIGHT_RST;
      cfg_q.attack_gain  <= alm_pkg::ATTACK_RST;
      cfg_q.release_gain <= alm_pkg::RELEASE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/alm_dp.sv -----
`timescale 1ns / 1ps
// alm_dp: accumulators, divider, square root, shape tables, smoother, output register
// depends on alm_pkg and alm_div

module alm_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [alm_pkg::SMP_W-1:0]    sample_i,
  input  logic                         last_i,
  input  alm_pkg::cfg_t                cfg_i,
  input  alm_pkg::cmd_t                cmd_i,
  output alm_pkg::status_t             status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [alm_pkg::Q16_W-1:0]    rms_level_o,
  output logic [alm_pkg::Q16_W-1:0]    peak_level_o,
  output logic [alm_pkg::Q16_W-1:0]    smoothed_level_o,
  output logic                         overflow_o
);

  localparam int unsigned W = alm_pkg::Q16_W;

  // accumulators
  logic [alm_pkg::SUM_W-1:0] sum_q;
  logic [alm_pkg::CNT_W-1:0] cnt_q;
  logic [alm_pkg::SMP_W-1:0] peak_q;
  logic                      sat_q;
  logic [alm_pkg::SUM_W-1:0] sum_d;
  logic [alm_pkg::CNT_W-1:0] cnt_d;
  logic [alm_pkg::SMP_W-1:0] peak_d;
  logic                      sat_d;
  logic [alm_pkg::SMP_W-1:0] mag;
  logic [2*alm_pkg::SMP_W-1:0] sq;
  logic                      full;

  // run snapshot
  logic [alm_pkg::SUM_W-1:0] w_sum_q;
  logic [alm_pkg::CNT_W-1:0] w_cnt_q;
  logic [alm_pkg::SMP_W-1:0] w_peak_q;
  logic                      w_sat_q;
  logic [W-1:0]              peak17;

  always_comb begin
    mag    = sample_i[alm_pkg::SMP_W-1] ? alm_pkg::SMP_W'(~sample_i + 1'b1) : sample_i;
    sq     = mag * mag;
    full   = cnt_q == alm_pkg::CNT_W'(alm_pkg::MAX_SAMPLES);
    peak_d = (mag > peak_q) ? mag : peak_q;
    sum_d  = full ? sum_q : sum_q + alm_pkg::SUM_W'(sq);
    cnt_d  = full ? cnt_q : cnt_q + 1'b1;
    sat_d  = sat_q | full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      peak_q <= '0;
      sat_q  <= 1'b0;
    end else if (cmd_i.take) begin
      if (last_i) begin
        sum_q  <= '0;
        cnt_q  <= '0;
        peak_q <= '0;
        sat_q  <= 1'b0;
      end else begin
        sum_q  <= sum_d;
        cnt_q  <= cnt_d;
        peak_q <= peak_d;
        sat_q  <= sat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && last_i) begin
      w_sum_q  <= sum_d;
      w_cnt_q  <= cnt_d;
      w_peak_q <= peak_d;
      w_sat_q  <= sat_d;
    end
  end

  assign peak17 = {w_peak_q, 1'b0};

  // shared divider
  logic [W-1:0]              rms_q;
  logic [W-1:0]              x_sel;
  logic [W-1:0]              c_sel;
  logic [W-1:0]              x_m_g;
  logic [W-1:0]              c_m_g;
  logic [alm_pkg::DIV_W-1:0] dividend;
  logic [W-1:0]              divisor;
  logic [alm_pkg::DIV_W-1:0] quo;
  logic                      div_busy;
  logic [W-1:0]              map_val;

  always_comb begin
    x_sel = (cmd_i.div_sel == alm_pkg::DIV_MAP_PEAK) ? peak17 : rms_q;
    c_sel = (cmd_i.div_sel == alm_pkg::DIV_MAP_PEAK) ? cfg_i.peak_ceiling : cfg_i.rms_ceiling;
    x_m_g = x_sel - cfg_i.gate_level;
    c_m_g = c_sel - cfg_i.gate_level;
    if (cmd_i.div_sel == alm_pkg::DIV_MEAN) begin
      dividend = alm_pkg::DIV_W'({w_sum_q, 2'b00});
      divisor  = W'(w_cnt_q);
    end else begin
      dividend = alm_pkg::DIV_W'({x_m_g, 16'd0});
      divisor  = c_m_g;
    end
    if (x_sel <= cfg_i.gate_level) begin
      map_val = '0;
    end else if (c_sel <= cfg_i.gate_level) begin
      map_val = alm_pkg::Q16_ONE;
    end else if (quo > alm_pkg::DIV_W'(alm_pkg::Q16_ONE)) begin
      map_val = alm_pkg::Q16_ONE;
    end else begin
      map_val = quo[W-1:0];
    end
  end

  alm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // square root, two bits per step
  logic [alm_pkg::SQRT_W-1:0] sq_x_q;
  logic [alm_pkg::SQRT_W:0]   sq_r_q;
  logic [alm_pkg::SQRT_W-1:0] sq_bit_q;
  logic [alm_pkg::SQRT_W:0]   sq_t;

  assign sq_t = sq_r_q + {1'b0, sq_bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_bit_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      sq_bit_q <= alm_pkg::SQRT_W'(1) << (alm_pkg::SQRT_W - 1);
    end else begin
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sq_x_q <= quo[alm_pkg::SQRT_W-1:0];
      sq_r_q <= '0;
    end else if (sq_bit_q != '0) begin
      if ({1'b0, sq_x_q} >= sq_t) begin
        sq_x_q <= alm_pkg::SQRT_W'({1'b0, sq_x_q} - sq_t);
        sq_r_q <= (sq_r_q >> 1) + {1'b0, sq_bit_q};
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
    end
  end

  assign rms_q = sq_r_q[W-1:0];

  // mapped levels
  logic [W-1:0] mapr_q;
  logic [W-1:0] mapp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_store) begin
      if (cmd_i.div_sel == alm_pkg::DIV_MAP_PEAK) begin
        mapp_q <= map_val;
      end else begin
        mapr_q <= map_val;
      end
    end
  end

  // table reads
  logic [alm_pkg::IDX_W-1:0]     idx_r, idx_rn, idx_p, idx_pn;
  logic [alm_pkg::FRAC_BITS-1:0] fr_r, fr_p;
  logic [alm_pkg::FRAC_BITS-1:0] fr_r_q, fr_p_q;
  logic [W-1:0]                  ra_q, rb_q, pa_q, pb_q;

  always_comb begin
    idx_r  = mapr_q[W-1] ? alm_pkg::IDX_W'(1 << alm_pkg::POW_TABLE_BITS)
                         : {1'b0, mapr_q[15:alm_pkg::FRAC_BITS]};
    idx_rn = mapr_q[W-1] ? idx_r : idx_r + 1'b1;
    fr_r   = mapr_q[W-1] ? '0 : mapr_q[alm_pkg::FRAC_BITS-1:0];
    idx_p  = mapp_q[W-1] ? alm_pkg::IDX_W'(1 << alm_pkg::POW_TABLE_BITS)
                         : {1'b0, mapp_q[15:alm_pkg::FRAC_BITS]};
    idx_pn = mapp_q[W-1] ? idx_p : idx_p + 1'b1;
    fr_p   = mapp_q[W-1] ? '0 : mapp_q[alm_pkg::FRAC_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rom_rd) begin
      ra_q   <= alm_pkg::RMS_SHAPE[idx_r];
      rb_q   <= alm_pkg::RMS_SHAPE[idx_rn];
      pa_q   <= alm_pkg::PEAK_SHAPE[idx_p];
      pb_q   <= alm_pkg::PEAK_SHAPE[idx_pn];
      fr_r_q <= fr_r;
      fr_p_q <= fr_p;
    end
  end

  function automatic logic [W-1:0] interp(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [alm_pkg::FRAC_BITS-1:0] fr);
    logic [W+alm_pkg::FRAC_BITS-1:0] p;
    if (b >= a) begin
      p = (b - a) * fr;
      return a + W'(p >> alm_pkg::FRAC_BITS);
    end else begin
      p = (a - b) * fr;
      return a - W'(p >> alm_pkg::FRAC_BITS);
    end
  endfunction

  // shaping, weighting and smoothing
  logic [W-1:0]   rs_q, ps_q, tgt_q, level_q;
  logic [W-1:0]   wgt, att, rel, gain, ps_w, mx;
  logic [2*W-1:0] wprod;
  logic [W-1:0]   diff;
  logic [2*W-1:0] sprod;
  logic           up;

  always_comb begin
    wgt   = (cfg_i.peak_weight  > alm_pkg::Q16_ONE) ? alm_pkg::Q16_ONE : cfg_i.peak_weight;
    att   = (cfg_i.attack_gain  > alm_pkg::Q16_ONE) ? alm_pkg::Q16_ONE : cfg_i.attack_gain;
    rel   = (cfg_i.release_gain > alm_pkg::Q16_ONE) ? alm_pkg::Q16_ONE : cfg_i.release_gain;
    wprod = ps_q * wgt;
    ps_w  = W'(wprod >> 16);
    mx    = (rs_q > ps_w) ? rs_q : ps_w;
    up    = tgt_q > level_q;
    diff  = up ? tgt_q - level_q : level_q - tgt_q;
    gain  = up ? att : rel;
    sprod = diff * gain;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      rs_q <= interp(ra_q, rb_q, fr_r_q);
      ps_q <= interp(pa_q, pb_q, fr_p_q);
    end
    if (cmd_i.weight) begin
      tgt_q <= (mx > alm_pkg::Q16_ONE) ? alm_pkg::Q16_ONE : mx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (cmd_i.smooth) begin
      level_q <= up ? level_q + W'(sprod >> 16) : level_q - W'(sprod >> 16);
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rms_level_o      <= rms_q;
      peak_level_o     <= peak17;
      smoothed_level_o <= level_q;
      overflow_o       <= w_sat_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.div_busy  = div_busy;
  assign status_o.sqrt_busy = sq_bit_q != '0;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// ----- hw/rtl/alm_ctrl.sv -----
`timescale 1ns / 1ps
// alm_ctrl: sequencer for accumulation and the end-of-run computation
// depends on alm_pkg

module alm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_i,
  output logic             in_ready_o,
  input  alm_pkg::status_t status_i,
  output alm_pkg::cmd_t    cmd_o
);

  alm_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      alm_pkg::S_IDLE:      if (in_valid_i && last_i) state_d = alm_pkg::S_MEAN_GO;
      alm_pkg::S_MEAN_GO:   state_d = alm_pkg::S_MEAN_WAIT;
      alm_pkg::S_MEAN_WAIT: if (!status_i.div_busy) state_d = alm_pkg::S_SQRT;
      alm_pkg::S_SQRT:      if (!status_i.sqrt_busy) state_d = alm_pkg::S_MAPR_GO;
      alm_pkg::S_MAPR_GO:   state_d = alm_pkg::S_MAPR_WAIT;
      alm_pkg::S_MAPR_WAIT: if (!status_i.div_busy) state_d = alm_pkg::S_MAPP_GO;
      alm_pkg::S_MAPP_GO:   state_d = alm_pkg::S_MAPP_WAIT;
      alm_pkg::S_MAPP_WAIT: if (!status_i.div_busy) state_d = alm_pkg::S_ROM;
      alm_pkg::S_ROM:       state_d = alm_pkg::S_MIX;
      alm_pkg::S_MIX:       state_d = alm_pkg::S_WEIGHT;
      alm_pkg::S_WEIGHT:    state_d = alm_pkg::S_SMOOTH;
      alm_pkg::S_SMOOTH:    state_d = alm_pkg::S_OUT;
      alm_pkg::S_OUT:       if (!status_i.out_busy) state_d = alm_pkg::S_IDLE;
      default:              state_d = alm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      alm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      alm_pkg::S_MEAN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = alm_pkg::DIV_MEAN;
      end
      alm_pkg::S_MEAN_WAIT: begin
        cmd_o.div_sel    = alm_pkg::DIV_MEAN;
        cmd_o.sqrt_start = !status_i.div_busy;
      end
      alm_pkg::S_MAPR_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = alm_pkg::DIV_MAP_RMS;
      end
      alm_pkg::S_MAPR_WAIT: begin
        cmd_o.div_sel   = alm_pkg::DIV_MAP_RMS;
        cmd_o.map_store = !status_i.div_busy;
      end
      alm_pkg::S_MAPP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = alm_pkg::DIV_MAP_PEAK;
      end
      alm_pkg::S_MAPP_WAIT: begin
        cmd_o.div_sel   = alm_pkg::DIV_MAP_PEAK;
        cmd_o.map_store = !status_i.div_busy;
      end
      alm_pkg::S_ROM:    cmd_o.rom_rd   = 1'b1;
      alm_pkg::S_MIX:    cmd_o.mix      = 1'b1;
      alm_pkg::S_WEIGHT: cmd_o.weight   = 1'b1;
      alm_pkg::S_SMOOTH: cmd_o.smooth   = 1'b1;
      alm_pkg::S_OUT:    cmd_o.out_load = !status_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- dv/alm_level_checker.sv -----
`timescale 1ns / 1ps
// alm_level_checker: watches the sample, level and register ports of audio_level_meter,
// predicts each run's levels and compares them; depends on alm_pkg

module alm_level_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [15:0]         sample_i,
  input  logic                       last_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [16:0]                rms_level_i,
  input  logic [16:0]                peak_level_i,
  input  logic [16:0]                smoothed_level_i,
  input  logic                       overflow_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [alm_pkg::ADDR_W-1:0] paddr,
  input  logic [alm_pkg::DATA_W-1:0] pwdata,
  output int                         fail_count_o,
  output int                         pending_o
);
  import alm_pkg::*;

  typedef struct {
    logic [16:0] rms;
    logic [16:0] peak;
    logic [16:0] level;
    logic        ovf;
  } levels_t;

  levels_t             levels_q[$];
  longint unsigned     rms_curve [TAB_LEN];
  longint unsigned     peak_curve[TAB_LEN];
  longint unsigned     sq_sum;
  int unsigned         n_samples;
  int unsigned         peak_mag;
  int unsigned         level;
  bit                  saturated;
  int unsigned         gate, rms_ceil, peak_ceil, weight, attack, release_g;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned x, r, b;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_fixed(input int unsigned v);
    int              e;
    longint unsigned m, frac;
    e = 0;
    frac = 0;
    while ((v >> e) > 1) e++;
    m = longint'(v) << (30 - e);
    for (int k = 1; k <= LOG_FRAC; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (LOG_FRAC - k));
      end
    end
    return (longint'(e) << LOG_FRAC) + frac;
  endfunction

  function automatic int unsigned norm_level(input int unsigned x, g, c);
    longint unsigned n;
    if (x <= g) return 0;
    if (c <= g) return 65536;
    n = (longint'(x - g) << 16) / longint'(c - g);
    return (n > 65536) ? 65536 : int'(n);
  endfunction

  function automatic int unsigned curve_lookup(input bit pk, input int unsigned n);
    int unsigned idx, fr, a, b;
    if (n >= 65536) return pk ? peak_curve[TAB_LEN-1] : rms_curve[TAB_LEN-1];
    idx = n >> FRAC_BITS;
    fr  = n & ((1 << FRAC_BITS) - 1);
    a   = pk ? peak_curve[idx] : rms_curve[idx];
    b   = pk ? peak_curve[idx+1] : rms_curve[idx+1];
    if (b >= a) return a + ((b - a) * fr >> FRAC_BITS);
    return a - ((a - b) * fr >> FRAC_BITS);
  endfunction

  function automatic int unsigned clip_one(input int unsigned v);
    return (v > 65536) ? 65536 : v;
  endfunction

  function automatic levels_t close_run();
    levels_t         res;
    int unsigned     rms, peak, rs, ps, target;
    longint unsigned step;
    rms  = int'(int_sqrt((sq_sum << 2) / n_samples));
    peak = peak_mag << 1;
    rs = curve_lookup(0, norm_level(rms, gate, rms_ceil));
    ps = curve_lookup(1, norm_level(peak, gate, peak_ceil));
    ps = int'((longint'(ps) * clip_one(weight)) >> 16);
    target = clip_one(rs > ps ? rs : ps);
    if (target > level) begin
      step = (longint'(target - level) * clip_one(attack)) >> 16;
      level = level + int'(step);
    end else begin
      step = (longint'(level - target) * clip_one(release_g)) >> 16;
      level = level - int'(step);
    end
    res.rms = rms[16:0];
    res.peak = peak[16:0];
    res.level = level[16:0];
    res.ovf = saturated;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v, got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  initial begin
    longint unsigned q[LOG_FRAC+1];
    longint unsigned mag, sc, ip, y, num;
    fail_count_o = 0;
    pending_o = 0;
    q[0] = 0;
    q[1] = int_sqrt(64'd1 << 59);
    for (int k = 2; k <= LOG_FRAC; k++) q[k] = int_sqrt(q[k-1] << 30);
    for (int t = 0; t < 2; t++) begin
      num = t ? 11 : 9;
      for (int i = 0; i < TAB_LEN; i++) begin
        y = 0;
        if (i > 0) begin
          mag = (longint'(POW_TABLE_BITS) << LOG_FRAC) - log2_fixed(i);
          sc  = mag * num / 20;
          ip  = sc >> LOG_FRAC;
          y   = 64'd1 << 30;
          for (int k = 1; k <= LOG_FRAC; k++)
            if ((sc >> (LOG_FRAC - k)) & 1) y = (y * q[k]) >> 30;
          y = (ip + 14 >= 64) ? 0 : ((y >> (ip + 14)) & 64'h1FFFF);
        end
        if (t) peak_curve[i] = y;
        else rms_curve[i] = y;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    levels_t     want;
    int unsigned mag;
    if (!rst_ni) begin
      levels_q.delete();
      sq_sum = 0;
      n_samples = 0;
      peak_mag = 0;
      level = 0;
      saturated = 0;
      gate = 393;
      rms_ceil = 16384;
      peak_ceil = 58982;
      weight = 47186;
      attack = 38011;
      release_g = 10486;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_GATE:        gate = pwdata[16:0];
          REG_RMS_CEIL:    rms_ceil = pwdata[16:0];
          REG_PEAK_CEIL:   peak_ceil = pwdata[16:0];
          REG_PEAK_WEIGHT: weight = pwdata[16:0];
          REG_ATTACK:      attack = pwdata[16:0];
          REG_RELEASE:     release_g = pwdata[16:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (levels_q.size() == 0) begin
          $display("%0t: result expected none got rms %0d peak %0d level %0d ovf %0d",
                   $time, rms_level_i, peak_level_i, smoothed_level_i, overflow_i);
          fail_count_o++;
        end else begin
          want = levels_q.pop_front();
          check_field("rms_level", want.rms, rms_level_i);
          check_field("peak_level", want.peak, peak_level_i);
          check_field("smoothed_level", want.level, smoothed_level_i);
          check_field("overflow", want.ovf, overflow_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        mag = (sample_i < 0) ? int'(-int'(sample_i)) : int'(sample_i);
        if (mag > peak_mag) peak_mag = mag;
        if (n_samples < MAX_SAMPLES) begin
          n_samples++;
          sq_sum += longint'(mag) * mag;
        end else begin
          saturated = 1;
        end
        if (last_i) begin
          levels_q.push_back(close_run());
          sq_sum = 0;
          n_samples = 0;
          peak_mag = 0;
          saturated = 0;
        end
      end
    end
    pending_o = levels_q.size();
  end

endmodule

// ----- dv/tb_audio_level_meter.sv -----
`timescale 1ns / 1ps
// tb_audio_level_meter: stimulus, register settings and verdict for audio_level_meter
// depends on alm_pkg, the block's rtl and alm_level_checker

module tb_audio_level_meter;
  import alm_pkg::*;

  localparam int LIMIT = 600000;

  logic                clk, rst_n;
  logic                in_valid, in_ready, last;
  logic signed [15:0]  sample;
  logic                out_valid, out_ready;
  logic [16:0]         rms_level, peak_level, smoothed_level;
  logic                overflow;
  logic                psel, penable, pwrite, pready;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata, prdata;
  int                  fail_count, pending;
  int                  cycles, n_samples, n_runs, n_settings;
  bit                  no_gaps, hold_req;

  audio_level_meter u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .sample_i(sample), .last_i(last),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .rms_level_o(rms_level), .peak_level_o(peak_level),
    .smoothed_level_o(smoothed_level), .overflow_o(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  alm_level_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .sample_i(sample), .last_i(last),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .rms_level_i(rms_level), .peak_level_i(peak_level),
    .smoothed_level_i(smoothed_level), .overflow_i(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    int stall;
    bit rdy;
    stall = 0;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 0;
        repeat (800) @(negedge clk);
        hold_req = 0;
      end else begin
        if (stall > 0) begin
          stall--;
          rdy = 0;
        end else if ($urandom_range(0, 9) < 7) begin
          rdy = 1;
        end else begin
          rdy = 0;
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        end
        out_ready = rdy;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 600)) - 300);
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      3: return 16'($urandom_range(0, 1) ? $urandom_range(1000, 20000)
                                         : -int'($urandom_range(1000, 20000)));
      4: return 16'sd0;
      default: return 16'($urandom_range(0, 8000));
    endcase
  endfunction

  task automatic send(input logic signed [15:0] s, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    sample = s;
    last = l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_samples++;
    if (l) n_runs++;
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send(pick_sample(), i == len - 1);
  endtask

  task automatic reg_write(input reg_idx_e idx, input int unsigned val);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = ADDR_W'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
  endtask

  task automatic apply_setting(input int unsigned g, rc, pc, w, a, r);
    in_valid = 0;
    wait (pending == 0);
    repeat (250) @(negedge clk);
    reg_write(REG_GATE, g);
    reg_write(REG_RMS_CEIL, rc);
    reg_write(REG_PEAK_CEIL, pc);
    reg_write(REG_PEAK_WEIGHT, w);
    reg_write(REG_ATTACK, a);
    reg_write(REG_RELEASE, r);
    n_settings++;
  endtask

  task automatic random_runs(input int quota);
    int sent;
    int len;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      send_run(len);
      sent += len;
    end
    no_gaps = 0;
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    sample = '0;
    last = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    hold_req = 0;
    no_gaps = 0;
    n_samples = 0;
    n_runs = 0;
    n_settings = 1;
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: extremes, loud then silent runs for attack and release
    send(16'sh7FFF, 1);
    send(16'sh8000, 1);
    send(16'sd0, 1);
    send(-16'sd1, 1);
    send(16'sd1, 1);
    send(16'sh8000, 0);
    send(16'sh7FFF, 0);
    send(16'sd12345, 0);
    send(-16'sd20000, 1);
    send(16'sd200, 0);
    send(-16'sd150, 1);
    for (int i = 0; i < 6; i++) send(16'sh7FFF, i == 5);
    for (int i = 0; i < 4; i++) send(16'sd0, i == 3);
    random_runs(60);

    // ceiling at or below the gate, zero gains
    apply_setting(0, 0, 0, 0, 0, 0);
    random_runs(60);

    // full-scale settings, with one long receiver hold and a burst of runs behind it
    apply_setting(0, 65536, 65536, 65536, 65536, 65536);
    hold_req = 1;
    no_gaps = 1;
    for (int i = 0; i < 16; i++) send_run($urandom_range(1, 3));
    no_gaps = 0;
    random_runs(60);

    // out-of-range register values and writes to unused addresses
    apply_setting(100, 200, 131071, 131071, 131071, 131071);
    reg_write(reg_idx_e'(6), $urandom);
    reg_write(reg_idx_e'(7), $urandom);
    random_runs(60);

    // gate above the rms ceiling
    apply_setting(30000, 20000, 131071 - 65536, 65536, 40000, 1);
    random_runs(50);

    for (int s = 0; s < 2; s++) begin
      apply_setting($urandom_range(0, 4000), $urandom_range(0, 65536),
                    $urandom_range(0, 65536), $urandom_range(0, 65536),
                    $urandom_range(0, 65536), $urandom_range(0, 65536));
      random_runs(50);
    end

    in_valid = 0;
    wait (pending == 0);
    repeat (300) @(negedge clk);
    $display("sent %0d samples in %0d runs under %0d register settings,", n_samples, n_runs,
             n_settings);
    $display("including gate/ceiling corners, full-scale samples and a long output stall");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
